### hdl/pis_pkg.sv
// shared types, constants and helpers for the particle integrator pipeline
// used by every module under hdl
`default_nettype none
package pis_pkg;
	localparam int FRAC_BITS = 16;
	localparam int W = 32;
	localparam int SIDE_W = 6 * W;
	localparam int SQRT_STEPS = W;
	localparam int DIV_STEPS = W - 1;
	localparam int WIDE_W = W + 2;

	typedef logic [W-1:0] word_t;
	typedef word_t [2:0] vec3_t;
	typedef logic [WIDE_W-1:0] wide_t;
	typedef wide_t [2:0] wvec3_t;

	localparam logic signed [WIDE_W-1:0] GRAVITY_Z = -(WIDE_W'(981) <<< FRAC_BITS);

	typedef enum logic [2:0] {
		REG_MAX_ACCEL,
		REG_MAX_SPEED,
		REG_RESTITUTION,
		REG_FRICTION,
		REG_TIME_STEP,
		REG_WALL_X,
		REG_WALL_Y,
		REG_WALL_Z
	} reg_idx_t;

	localparam logic signed [39:0] SAT_HI = 40'sh007FFFFFFF;
	localparam logic signed [39:0] SAT_LO = -40'sh0080000000;

	function automatic word_t sat32(input logic signed [39:0] v);
		word_t r;
		if (v > SAT_HI) begin
			r = 32'h7FFFFFFF;
		end else if (v < SAT_LO) begin
			r = 32'h80000000;
		end else begin
			r = v[W-1:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

### hdl/pis_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on pis_pkg
`default_nettype none
module pis_sqrt
	import pis_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        ce,
	input  wire logic [63:0] x,
	output logic [W-1:0]     root
);
	logic [63:0]  x_s    [SQRT_STEPS];
	logic [34:0]  rem_s  [SQRT_STEPS];
	logic [W-1:0] root_s [SQRT_STEPS];

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
		logic [63:0]  xi;
		logic [34:0]  ri;
		logic [W-1:0] qi;
		logic [34:0]  r2;
		logic [34:0]  tr;
		if (i == 0) begin : g_first
			assign xi = x;
			assign ri = '0;
			assign qi = '0;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign ri = rem_s[i-1];
			assign qi = root_s[i-1];
		end
		assign r2 = {ri[32:0], xi[63:62]};
		assign tr = {1'b0, qi, 2'b01};
		always_ff @(posedge clk) begin
			if (ce) begin
				x_s[i] <= {xi[61:0], 2'b00};
				if (r2 >= tr) begin
					rem_s[i]  <= r2 - tr;
					root_s[i] <= {qi[W-2:0], 1'b1};
				end else begin
					rem_s[i]  <= r2;
					root_s[i] <= {qi[W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[SQRT_STEPS-1];
endmodule
`default_nettype wire

### hdl/pis_div.sv
// pipelined restoring divider, 62-bit dividend by 32-bit divisor, 31-bit quotient
// depends on pis_pkg
`default_nettype none
module pis_div
	import pis_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          ce,
	input  wire logic [61:0]   num,
	input  wire logic [W-1:0]  den,
	output logic [DIV_STEPS-1:0] quo
);
	logic [DIV_STEPS-1:0] lo_s  [DIV_STEPS];
	logic [W-1:0]         rem_s [DIV_STEPS];
	logic [W-1:0]         den_s [DIV_STEPS];
	logic [DIV_STEPS-1:0] q_s   [DIV_STEPS];

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic [DIV_STEPS-1:0] li;
		logic [W-1:0]         ri;
		logic [W-1:0]         di;
		logic [DIV_STEPS-1:0] qi;
		logic [W:0]           r2;
		if (i == 0) begin : g_first
			assign li = num[DIV_STEPS-1:0];
			assign ri = {1'b0, num[61:DIV_STEPS]};
			assign di = den;
			assign qi = '0;
		end else begin : g_next
			assign li = lo_s[i-1];
			assign ri = rem_s[i-1];
			assign di = den_s[i-1];
			assign qi = q_s[i-1];
		end
		assign r2 = {ri, li[DIV_STEPS-1]};
		always_ff @(posedge clk) begin
			if (ce) begin
				lo_s[i]  <= {li[DIV_STEPS-2:0], 1'b0};
				den_s[i] <= di;
				if (r2 >= {1'b0, di}) begin
					rem_s[i] <= W'(r2 - {1'b0, di});
					q_s[i]   <= {qi[DIV_STEPS-2:0], 1'b1};
				end else begin
					rem_s[i] <= r2[W-1:0];
					q_s[i]   <= {qi[DIV_STEPS-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = q_s[DIV_STEPS-1];
endmodule
`default_nettype wire

### hdl/pis_limit.sv
// vector magnitude limiter: squares, sum, sqrt pipeline, three dividers
// depends on pis_pkg, pis_sqrt, pis_div
`default_nettype none
module pis_limit
	import pis_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              ce,
	input  wire logic              in_valid,
	input  wire vec3_t             vec,
	input  wire logic [W-2:0]      lim,
	input  wire logic [SIDE_W-1:0] side,
	output logic                   out_valid,
	output vec3_t                  out_vec,
	output logic [SIDE_W-1:0]      out_side
);
	localparam int D = SQRT_STEPS + DIV_STEPS;

	logic [W-1:0]  mag [3];
	logic [63:0]   sq_s1 [3];
	logic [61:0]   prod_s1 [3];
	logic [61:0]   limsq_s1;
	vec3_t         vec_s1;
	logic [SIDE_W-1:0] side_s1;
	logic          valid_s1;

	logic [63:0]   m2_s2;
	logic [61:0]   limsq_s2;
	logic [61:0]   prod_s2 [3];
	vec3_t         vec_s2;
	logic [SIDE_W-1:0] side_s2;
	logic          valid_s2;

	vec3_t         vec_sd [D];
	logic [SIDE_W-1:0] side_sd [D];
	logic [D-1:0]  over_sd;
	logic [D-1:0]  valid_sd;
	logic [61:0]   prod_sd [SQRT_STEPS][3];

	logic [W-1:0]  root;
	logic [DIV_STEPS-1:0] quo [3];

	vec3_t         vec_s3;
	logic [SIDE_W-1:0] side_s3;
	logic          valid_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = vec[i][W-1] ? W'(-vec[i]) : vec[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_sd <= '0;
			valid_s3 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_sd <= {valid_sd[D-2:0], valid_s2};
			valid_s3 <= valid_sd[D-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i]   <= mag[i] * mag[i];
				prod_s1[i] <= mag[i] * lim;
				prod_s2[i] <= prod_s1[i];
			end
			limsq_s1 <= lim * lim;
			vec_s1   <= vec;
			side_s1  <= side;

			m2_s2    <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			limsq_s2 <= limsq_s1;
			vec_s2   <= vec_s1;
			side_s2  <= side_s1;

			vec_sd[0]  <= vec_s2;
			side_sd[0] <= side_s2;
			over_sd    <= {over_sd[D-2:0], (m2_s2 > {2'b00, limsq_s2})};
			for (int k = 1; k < D; k++) begin
				vec_sd[k]  <= vec_sd[k-1];
				side_sd[k] <= side_sd[k-1];
			end
			for (int i = 0; i < 3; i++) begin
				prod_sd[0][i] <= prod_s2[i];
				for (int k = 1; k < SQRT_STEPS; k++) begin
					prod_sd[k][i] <= prod_sd[k-1][i];
				end
			end

			side_s3 <= side_sd[D-1];
			for (int i = 0; i < 3; i++) begin
				if (!over_sd[D-1]) begin
					vec_s3[i] <= vec_sd[D-1][i];
				end else if (vec_sd[D-1][i][W-1]) begin
					vec_s3[i] <= W'(-{1'b0, quo[i]});
				end else begin
					vec_s3[i] <= {1'b0, quo[i]};
				end
			end
		end
	end

	pis_sqrt u_sqrt (
		.clk  (clk),
		.ce   (ce),
		.x    (m2_s2),
		.root (root)
	);

	for (genvar i = 0; i < 3; i++) begin : g_div
		pis_div u_div (
			.clk (clk),
			.ce  (ce),
			.num (prod_sd[SQRT_STEPS-1][i]),
			.den (root),
			.quo (quo[i])
		);
	end

	assign out_valid = valid_s3;
	assign out_vec   = vec_s3;
	assign out_side  = side_s3;
endmodule
`default_nettype wire

### hdl/pis_axpy.sv
// two-stage base + rate * dt update with floor shift and 32-bit saturation
// depends on pis_pkg
`default_nettype none
module pis_axpy
	import pis_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             ce,
	input  wire logic             in_valid,
	input  wire vec3_t            base,
	input  wire wvec3_t           rate,
	input  wire logic [16:0]      dt,
	input  wire logic [3*W-1:0]   side,
	output logic                  out_valid,
	output vec3_t                 res,
	output logic [3*W-1:0]        out_side
);
	logic signed [WIDE_W+17:0] prod_s1 [3];
	vec3_t          base_s1;
	logic [3*W-1:0] side_s1;
	logic           valid_s1;
	vec3_t          res_s2;
	logic [3*W-1:0] side_s2;
	logic           valid_s2;
	logic signed [39:0] sum [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = 40'($signed(base_s1[i])) + 40'(prod_s1[i] >>> FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= $signed(rate[i]) * $signed({1'b0, dt});
				res_s2[i]  <= sat32(sum[i]);
			end
			base_s1 <= base;
			side_s1 <= side;
			side_s2 <= side_s1;
		end
	end

	assign out_valid = valid_s2;
	assign res       = res_s2;
	assign out_side  = side_s2;
endmodule
`default_nettype wire

### hdl/pis_wall.sv
// two-stage wall test and bounce on one selected axis
// depends on pis_pkg
`default_nettype none
module pis_wall
	import pis_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        ce,
	input  wire logic        in_valid,
	input  wire logic [1:0]  axis,
	input  wire vec3_t       pos,
	input  wire vec3_t       vel,
	input  wire logic [63:0] wall,
	input  wire logic [17:0] restitution,
	input  wire logic [17:0] friction,
	output logic             out_valid,
	output vec3_t            out_pos,
	output vec3_t            out_vel
);
	logic signed [W-1:0] lo;
	logic signed [W-1:0] hi;
	logic signed [W-1:0] pa;
	logic signed [W-1:0] va;
	logic                hit_lo;
	logic                hit_hi;
	logic signed [18:0]  k [3];

	logic signed [W+18:0] prod_s1 [3];
	logic          hit_s1;
	word_t         wall_s1;
	vec3_t         pos_s1;
	vec3_t         vel_s1;
	logic [1:0]    axis_s1;
	logic          valid_s1;

	vec3_t         pos_s2;
	vec3_t         vel_s2;
	logic          valid_s2;

	always_comb begin
		lo = $signed(wall[W-1:0]);
		hi = $signed(wall[2*W-1:W]);
		pa = $signed(pos[axis]);
		va = $signed(vel[axis]);
		hit_lo = (pa <= lo) && (va < 0);
		hit_hi = !hit_lo && (pa >= hi) && (va > 0);
		for (int i = 0; i < 3; i++) begin
			if (i == int'(axis)) begin
				k[i] = -$signed({1'b0, restitution});
			end else begin
				k[i] = $signed({1'b0, friction});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= $signed(vel[i]) * k[i];
			end
			hit_s1   <= hit_lo || hit_hi;
			wall_s1  <= hit_lo ? lo : hi;
			pos_s1   <= pos;
			vel_s1   <= vel;
			axis_s1  <= axis;

			if (hit_s1) begin
				for (int i = 0; i < 3; i++) begin
					pos_s2[i] <= (i == int'(axis_s1)) ? wall_s1 : pos_s1[i];
					vel_s2[i] <= sat32(40'(prod_s1[i] >>> FRAC_BITS));
				end
			end else begin
				pos_s2 <= pos_s1;
				vel_s2 <= vel_s1;
			end
		end
	end

	assign out_valid = valid_s2;
	assign out_pos   = pos_s2;
	assign out_vel   = vel_s2;
endmodule
`default_nettype wire

### hdl/particle_integrate_wall_bounce.sv
// particle integrator with box walls, semi-implicit euler in signed q16.16
// pipeline from input word to output word: two magnitude limiters
// (each a 32-stage sqrt plus 31-stage dividers), two 2-stage
// multiply-add steps and three 2-stage wall units
// throughput one word per cycle; a stalled output holds the whole pipeline
// arst_n clears all valid bits and loads the register reset values
`default_nettype none
module particle_integrate_wall_bounce
	import pis_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_axis_tvalid,
	output logic                 s_axis_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z
	input  wire logic [9*W-1:0]  s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  wire logic            m_axis_tready,
	// new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
	output logic [6*W-1:0]       m_axis_tdata,
	input  wire logic            cfg_we,
	input  wire logic [2:0]      cfg_addr,
	input  wire logic [63:0]     cfg_wdata
);
	logic [W-2:0] max_accel_q;
	logic [W-2:0] max_speed_q;
	logic [17:0]  restitution_q;
	logic [17:0]  friction_q;
	logic [16:0]  time_step_q;
	logic [63:0]  wall_x_q;
	logic [63:0]  wall_y_q;
	logic [63:0]  wall_z_q;

	logic ce;

	logic              l1_valid;
	vec3_t             l1_acc;
	logic [SIDE_W-1:0] l1_side;
	wvec3_t            acc_w;

	logic              a1_valid;
	vec3_t             a1_vel;
	logic [3*W-1:0]    a1_pos;

	logic              l2_valid;
	vec3_t             l2_vel;
	logic [SIDE_W-1:0] l2_side;
	wvec3_t            vel_w;

	logic              a2_valid;
	vec3_t             a2_pos;
	logic [3*W-1:0]    a2_vel;

	logic              wx_valid;
	vec3_t             wx_pos;
	vec3_t             wx_vel;
	logic              wy_valid;
	vec3_t             wy_pos;
	vec3_t             wy_vel;
	logic              wz_valid;
	vec3_t             wz_pos;
	vec3_t             wz_vel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_accel_q   <= '1;
			max_speed_q   <= '1;
			restitution_q <= 18'd32768;
			friction_q    <= 18'd65536;
			time_step_q   <= '0;
			wall_x_q      <= '0;
			wall_y_q      <= '0;
			wall_z_q      <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_MAX_ACCEL:   max_accel_q   <= cfg_wdata[W-2:0];
				REG_MAX_SPEED:   max_speed_q   <= cfg_wdata[W-2:0];
				REG_RESTITUTION: restitution_q <= cfg_wdata[17:0];
				REG_FRICTION:    friction_q    <= cfg_wdata[17:0];
				REG_TIME_STEP:   time_step_q   <= cfg_wdata[16:0];
				REG_WALL_X:      wall_x_q      <= cfg_wdata;
				REG_WALL_Y:      wall_y_q      <= cfg_wdata;
				REG_WALL_Z:      wall_z_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign ce            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce;

	pis_limit u_limit_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (s_axis_tvalid),
		.vec       (vec3_t'(s_axis_tdata[9*W-1:6*W])),
		.lim       (max_accel_q),
		.side      (s_axis_tdata[6*W-1:0]),
		.out_valid (l1_valid),
		.out_vec   (l1_acc),
		.out_side  (l1_side)
	);

	// gravity on z, kept wide
	always_comb begin
		acc_w[0] = WIDE_W'($signed(l1_acc[0]));
		acc_w[1] = WIDE_W'($signed(l1_acc[1]));
		acc_w[2] = WIDE_W'($signed(l1_acc[2])) + GRAVITY_Z;
		vel_w[0] = WIDE_W'($signed(l2_vel[0]));
		vel_w[1] = WIDE_W'($signed(l2_vel[1]));
		vel_w[2] = WIDE_W'($signed(l2_vel[2]));
	end

	pis_axpy u_vel_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (l1_valid),
		.base      (vec3_t'(l1_side[6*W-1:3*W])),
		.rate      (acc_w),
		.dt        (time_step_q),
		.side      (l1_side[3*W-1:0]),
		.out_valid (a1_valid),
		.res       (a1_vel),
		.out_side  (a1_pos)
	);

	pis_limit u_limit_vel (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (a1_valid),
		.vec       (a1_vel),
		.lim       (max_speed_q),
		.side      ({{(SIDE_W-3*W){1'b0}}, a1_pos}),
		.out_valid (l2_valid),
		.out_vec   (l2_vel),
		.out_side  (l2_side)
	);

	pis_axpy u_pos_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (l2_valid),
		.base      (vec3_t'(l2_side[3*W-1:0])),
		.rate      (vel_w),
		.dt        (time_step_q),
		.side      (l2_vel),
		.out_valid (a2_valid),
		.res       (a2_pos),
		.out_side  (a2_vel)
	);

	pis_wall u_wall_x (
		.clk         (clk),
		.arst_n      (arst_n),
		.ce          (ce),
		.in_valid    (a2_valid),
		.axis        (2'd0),
		.pos         (a2_pos),
		.vel         (vec3_t'(a2_vel)),
		.wall        (wall_x_q),
		.restitution (restitution_q),
		.friction    (friction_q),
		.out_valid   (wx_valid),
		.out_pos     (wx_pos),
		.out_vel     (wx_vel)
	);

	pis_wall u_wall_y (
		.clk         (clk),
		.arst_n      (arst_n),
		.ce          (ce),
		.in_valid    (wx_valid),
		.axis        (2'd1),
		.pos         (wx_pos),
		.vel         (wx_vel),
		.wall        (wall_y_q),
		.restitution (restitution_q),
		.friction    (friction_q),
		.out_valid   (wy_valid),
		.out_pos     (wy_pos),
		.out_vel     (wy_vel)
	);

	pis_wall u_wall_z (
		.clk         (clk),
		.arst_n      (arst_n),
		.ce          (ce),
		.in_valid    (wy_valid),
		.axis        (2'd2),
		.pos         (wy_pos),
		.vel         (wy_vel),
		.wall        (wall_z_q),
		.restitution (restitution_q),
		.friction    (friction_q),
		.out_valid   (wz_valid),
		.out_pos     (wz_pos),
		.out_vel     (wz_vel)
	);

	assign m_axis_tvalid = wz_valid;
	assign m_axis_tdata  = {wz_vel, wz_pos};
endmodule
`default_nettype wire
